### rtl/core/look_at_view_matrix_macros.svh
// Assertion macros shared by the look-at view matrix RTL.
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LAVM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/lavm_pkg.sv
// Types and constants shared by the look-at view matrix modules.
package lavm_pkg;

   // Normalizer input word: covers eye - target and the raw side cross product
   localparam int VW       = 51;
   localparam int PSW      = 6;           // leading-one position
   localparam int NMW      = 30;          // normalized magnitude, msb at bit 29
   localparam int SQW      = 2 * NMW;
   localparam int SUMW     = SQW + 2;
   localparam int LENW     = SUMW / 2;    // square root width
   localparam int REMW     = LENW + 3;    // root remainder
   localparam int QW       = 17;          // unsigned quotient, at most 1.0
   localparam int OQW      = QW + 1;      // signed normalized component
   localparam int NUMW     = NMW + QW + 1;
   localparam int DENW     = LENW + 1;
   localparam int UW       = 20;          // camera up component

   localparam int SQ_STEPS  = LENW;
   localparam int SQ_PER    = 4;
   localparam int SQ_STAGES = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
   localparam int DIV_STEPS  = QW;
   localparam int DIV_PER    = 4;
   localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

   localparam logic [1:0]  ROW_FIRST = 2'd0;
   localparam logic [1:0]  ROW_LAST  = 2'd3;
   localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
   localparam logic [31:0] Q_ONE     = 32'h0001_0000;

   // Side data carried through the forward normalizer
   typedef struct packed {
      logic [2:0][31:0] eye;
      logic [2:0][31:0] up;
   } lavm_p1_type;

   // Side data carried through the side normalizer
   typedef struct packed {
      logic [2:0][31:0]    eye;
      logic [2:0][OQW-1:0] f;
      logic                degen;
   } lavm_p2_type;

   // Finished matrix handed to the row sequencer
   typedef struct packed {
      logic [2:0][OQW-1:0] s;
      logic [2:0][UW-1:0]  u;
      logic [2:0][OQW-1:0] f;
      logic [2:0][31:0]    d;
      logic                degen;
   } lavm_item_type;

endpackage

### rtl/core/lavm_isqrt.sv
// Pipelined integer square root, a few result bits per stage.
module lavm_isqrt import lavm_pkg::*; #(
   parameter int PW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [SUMW-1:0] in_x,
   input  logic [PW-1:0]   in_pay,
   output logic            out_valid,
   output logic [LENW-1:0] out_root,
   output logic [PW-1:0]   out_pay
);

   logic            v_ff    [SQ_STAGES+1];
   logic [REMW-1:0] rem_ff  [SQ_STAGES+1];
   logic [LENW-1:0] root_ff [SQ_STAGES+1];
   logic [SUMW-1:0] xr_ff   [SQ_STAGES+1];
   logic [PW-1:0]   pay_ff  [SQ_STAGES+1];

   // Capture stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         xr_ff[0]   <= in_x;
         pay_ff[0]  <= in_pay;
      end
   end

   // Digit-by-digit root, two radicand bits per step
   for (genvar j = 1; j <= SQ_STAGES; j++) begin : g_stage
      logic [REMW-1:0] rem_in;
      logic [LENW-1:0] root_in;
      logic [SUMW-1:0] xr_in;

      always_comb begin
         logic [REMW-1:0] r;
         logic [REMW-1:0] trial;
         rem_in  = rem_ff[j-1];
         root_in = root_ff[j-1];
         xr_in   = xr_ff[j-1];
         r       = '0;
         trial   = '0;
         for (int t = 0; t < SQ_PER; t++) begin
            if ((j - 1) * SQ_PER + t < SQ_STEPS) begin
               r     = {rem_in[REMW-3:0], xr_in[SUMW-1:SUMW-2]};
               xr_in = {xr_in[SUMW-3:0], 2'b00};
               trial = REMW'({root_in, 2'b01});
               if (r >= trial) begin
                  rem_in  = r - trial;
                  root_in = {root_in[LENW-2:0], 1'b1};
               end else begin
                  rem_in  = r;
                  root_in = {root_in[LENW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_ff[j-1];
         end
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            xr_ff[j]   <= xr_in;
            pay_ff[j]  <= pay_ff[j-1];
         end
      end
   end

   assign out_valid = v_ff[SQ_STAGES];
   assign out_root  = root_ff[SQ_STAGES];
   assign out_pay   = pay_ff[SQ_STAGES];

endmodule

### rtl/core/lavm_norm.sv
// Pipelined 3-vector normalizer to Q16.16 with zero-length detect.
module lavm_norm import lavm_pkg::*; #(
   parameter int PW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2:0][VW-1:0]  in_v,
   input  logic [PW-1:0]       in_pay,
   output logic                out_valid,
   output logic [2:0][OQW-1:0] out_q,
   output logic                out_zero,
   output logic [PW-1:0]       out_pay
);

   localparam int IPW = PW + 3 + 1 + 3 * NMW;

   // Stage 1: magnitudes and their OR
   logic                v1_ff;
   logic [2:0]          neg1_ff;
   logic [2:0][VW-1:0]  mag1_in, mag1_ff;
   logic [VW-1:0]       or1_ff;
   logic [PW-1:0]       pay1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = in_v[i][VW-1] ? (~in_v[i] + 1'b1) : in_v[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         neg1_ff <= {in_v[2][VW-1], in_v[1][VW-1], in_v[0][VW-1]};
         mag1_ff <= mag1_in;
         or1_ff  <= mag1_in[0] | mag1_in[1] | mag1_in[2];
         pay1_ff <= in_pay;
      end
   end

   // Stage 2: leading-one position of the largest magnitude
   logic                v2_ff, zero2_ff;
   logic [PSW-1:0]      pos2_in, pos2_ff;
   logic [2:0]          neg2_ff;
   logic [2:0][VW-1:0]  mag2_ff;
   logic [PW-1:0]       pay2_ff;

   always_comb begin
      pos2_in = '0;
      for (int b = 0; b < VW; b++) begin
         if (or1_ff[b]) pos2_in = PSW'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         pos2_ff  <= pos2_in;
         zero2_ff <= (or1_ff == '0);
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         pay2_ff  <= pay1_ff;
      end
   end

   // Stage 3: shift so the largest magnitude sits in [2^29, 2^30)
   logic                v3_ff, zero3_ff;
   logic [2:0]          neg3_ff;
   logic [2:0][NMW-1:0] m3_in, m3_ff;
   logic [PW-1:0]       pay3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff > PSW'(NMW - 1)) begin
            m3_in[i] = NMW'(mag2_ff[i] >> (pos2_ff - PSW'(NMW - 1)));
         end else begin
            m3_in[i] = NMW'(mag2_ff[i] << (PSW'(NMW - 1) - pos2_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         m3_ff    <= m3_in;
         zero3_ff <= zero2_ff;
         neg3_ff  <= neg2_ff;
         pay3_ff  <= pay2_ff;
      end
   end

   // Stage 4: squares
   logic                v4_ff, zero4_ff;
   logic [2:0]          neg4_ff;
   logic [2:0][SQW-1:0] sq4_ff;
   logic [2:0][NMW-1:0] m4_ff;
   logic [PW-1:0]       pay4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= SQW'(m3_ff[i]) * SQW'(m3_ff[i]);
         end
         m4_ff    <= m3_ff;
         zero4_ff <= zero3_ff;
         neg4_ff  <= neg3_ff;
         pay4_ff  <= pay3_ff;
      end
   end

   // Stage 5: sum of squares
   logic                v5_ff, zero5_ff;
   logic [2:0]          neg5_ff;
   logic [SUMW-1:0]     sum5_ff;
   logic [2:0][NMW-1:0] m5_ff;
   logic [PW-1:0]       pay5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         sum5_ff  <= SUMW'(sq4_ff[0]) + SUMW'(sq4_ff[1]) + SUMW'(sq4_ff[2]);
         m5_ff    <= m4_ff;
         zero5_ff <= zero4_ff;
         neg5_ff  <= neg4_ff;
         pay5_ff  <= pay4_ff;
      end
   end

   // Length
   logic                sq_v;
   logic [LENW-1:0]     sq_len;
   logic [IPW-1:0]      sq_pay;
   logic [PW-1:0]       s_pay;
   logic [2:0]          s_neg;
   logic                s_zero;
   logic [2:0][NMW-1:0] s_m;

   lavm_isqrt #(.PW(IPW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_x      (sum5_ff),
      .in_pay    ({pay5_ff, neg5_ff, zero5_ff, m5_ff}),
      .out_valid (sq_v),
      .out_root  (sq_len),
      .out_pay   (sq_pay)
   );

   assign {s_pay, s_neg, s_zero, s_m} = sq_pay;

   // Divider: q = (m * 2^17 + len) / (2 * len), one quotient bit per step
   logic                 dv_ff   [DIV_STAGES+1];
   logic [2:0][DENW-1:0] drem_ff [DIV_STAGES+1];
   logic [2:0][QW-1:0]   dlow_ff [DIV_STAGES+1];
   logic [2:0][QW-1:0]   dq_ff   [DIV_STAGES+1];
   logic [DENW-1:0]      dden_ff [DIV_STAGES+1];
   logic [2:0]           dneg_ff [DIV_STAGES+1];
   logic                 dzero_ff[DIV_STAGES+1];
   logic [PW-1:0]        dpay_ff [DIV_STAGES+1];
   logic [2:0][NUMW-1:0] num_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUMW'(s_m[i]) << QW) + NUMW'(sq_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sq_v;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= DENW'(num_in[i][NUMW-1:QW]);
            dlow_ff[0][i] <= num_in[i][QW-1:0];
         end
         dq_ff[0]    <= '0;
         dden_ff[0]  <= {sq_len, 1'b0};
         dneg_ff[0]  <= s_neg;
         dzero_ff[0] <= s_zero;
         dpay_ff[0]  <= s_pay;
      end
   end

   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      logic [2:0][DENW-1:0] rem_in;
      logic [2:0][QW-1:0]   low_in, q_in;

      always_comb begin
         logic [DENW:0] r;
         rem_in = drem_ff[j-1];
         low_in = dlow_ff[j-1];
         q_in   = dq_ff[j-1];
         r      = '0;
         for (int i = 0; i < 3; i++) begin
            for (int t = 0; t < DIV_PER; t++) begin
               if ((j - 1) * DIV_PER + t < DIV_STEPS) begin
                  r         = {rem_in[i], low_in[i][QW-1]};
                  low_in[i] = {low_in[i][QW-2:0], 1'b0};
                  if (r >= {1'b0, dden_ff[j-1]}) begin
                     rem_in[i] = DENW'(r - {1'b0, dden_ff[j-1]});
                     q_in[i]   = {q_in[i][QW-2:0], 1'b1};
                  end else begin
                     rem_in[i] = r[DENW-1:0];
                     q_in[i]   = {q_in[i][QW-2:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (en) begin
            dv_ff[j] <= dv_ff[j-1];
         end
         if (en) begin
            drem_ff[j]  <= rem_in;
            dlow_ff[j]  <= low_in;
            dq_ff[j]    <= q_in;
            dden_ff[j]  <= dden_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
            dzero_ff[j] <= dzero_ff[j-1];
            dpay_ff[j]  <= dpay_ff[j-1];
         end
      end
   end

   // Output stage: restore signs, zero vector on zero length
   logic                ov_ff, ozero_ff;
   logic [2:0][OQW-1:0] oq_in, oq_ff;
   logic [PW-1:0]       opay_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dzero_ff[DIV_STAGES]) begin
            oq_in[i] = '0;
         end else if (dneg_ff[DIV_STAGES][i]) begin
            oq_in[i] = ~{1'b0, dq_ff[DIV_STAGES][i]} + 1'b1;
         end else begin
            oq_in[i] = {1'b0, dq_ff[DIV_STAGES][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[DIV_STAGES];
      end
      if (en) begin
         oq_ff    <= oq_in;
         ozero_ff <= dzero_ff[DIV_STAGES];
         opay_ff  <= dpay_ff[DIV_STAGES];
      end
   end

   assign out_valid = ov_ff;
   assign out_q     = oq_ff;
   assign out_zero  = ozero_ff;
   assign out_pay   = opay_ff;

endmodule

### rtl/core/lavm_rowout.sv
// Row sequencer: holds one finished matrix and sends it as four row transactions.
module lavm_rowout import lavm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  lavm_item_type in_item,
   output logic          in_take,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_row_index,
   output logic [31:0]   rsp_col0,
   output logic [31:0]   rsp_col1,
   output logic [31:0]   rsp_col2,
   output logic [31:0]   rsp_col3,
   output logic          rsp_last_row,
   output logic          rsp_degenerate
);

   logic          full_ff;
   logic [1:0]    row_ff;
   lavm_item_type item_ff;

   // Free, or the last row leaves this cycle
   assign in_take = !full_ff || (row_ff == ROW_LAST && !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         row_ff  <= ROW_FIRST;
      end else begin
         priority if (in_take && in_valid) begin
            full_ff <= 1'b1;
            row_ff  <= ROW_FIRST;
         end else if (in_take) begin
            full_ff <= 1'b0;
         end else if (!rsp_stall) begin
            row_ff <= row_ff + 2'd1;
         end
      end
      if (in_take && in_valid) begin
         item_ff <= in_item;
      end
   end

   // Row select
   always_comb begin
      if (row_ff == ROW_LAST) begin
         rsp_col0 = item_ff.d[0];
         rsp_col1 = item_ff.d[1];
         rsp_col2 = item_ff.d[2];
         rsp_col3 = Q_ONE;
      end else begin
         rsp_col0 = 32'(signed'(item_ff.s[row_ff]));
         rsp_col1 = 32'(signed'(item_ff.u[row_ff]));
         rsp_col2 = 32'(signed'(item_ff.f[row_ff]));
         rsp_col3 = Q_ZERO;
      end
   end

   assign rsp_valid      = full_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_last_row   = (row_ff == ROW_LAST);
   assign rsp_degenerate = item_ff.degen;

endmodule

### rtl/core/look_at_view_matrix.sv
// Look-at view matrix generator: top level with vector arithmetic stages.
//
// Each request transaction carries eye, target and up vectors in signed Q16.16 and
// yields four response transactions, matrix rows 0 to 3 in order, one per cycle
// while rsp_stall is low. A new request can be taken every cycle while the pipeline
// has room; sustained throughput is bounded by the four-row response sequencer.
// From request to row 0 the data passes two normalizers of 21 register stages each
// (pipelined square root, 4 root bits a stage, and pipelined divider, 4 quotient bits
// a stage), plus cross and dot product stages. req_stall rises only
// when the last pipeline stage holds a matrix that the sequencer cannot yet take.
module look_at_view_matrix import lavm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_upward_x,
   input  logic signed [31:0] req_upward_y,
   input  logic signed [31:0] req_upward_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_col3,
   output logic               rsp_last_row,
   output logic               rsp_degenerate
);

`include "look_at_view_matrix_macros.svh"

   // Q32.32 to Q16.16, half away from zero
   function automatic logic signed [55:0] rnd16(input logic signed [55:0] v);
      logic [55:0] m;
      m = v[55] ? 56'(-v) : 56'(v);
      m = (m + 56'h8000) >> 16;
      return v[55] ? -signed'(m) : signed'(m);
   endfunction

   // Negate the rounded value and clamp to 32 bits
   function automatic logic [31:0] satneg(input logic signed [55:0] v);
      logic signed [55:0] r;
      r = -rnd16(v);
      if (r > 56'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      else if (r < -56'sh8000_0000) return 32'h8000_0000;
      else return r[31:0];
   endfunction

   logic          en;
   logic          take;
   logic          t7_v_ff;
   lavm_item_type item_ff;

   // Whole pipeline advances unless the tail is blocked
   assign en        = !t7_v_ff || take;
   assign req_stall = !en;

   // T0: eye - target
   logic               t0_v_ff;
   logic [2:0][VW-1:0] fr0_ff;
   lavm_p1_type        p0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_v_ff <= 1'b0;
      end else if (en) begin
         t0_v_ff <= req_valid;
      end
      if (en) begin
         fr0_ff[0] <= VW'(req_eye_x) - VW'(req_target_x);
         fr0_ff[1] <= VW'(req_eye_y) - VW'(req_target_y);
         fr0_ff[2] <= VW'(req_eye_z) - VW'(req_target_z);
         p0_ff.eye <= {req_eye_z, req_eye_y, req_eye_x};
         p0_ff.up  <= {req_upward_z, req_upward_y, req_upward_x};
      end
   end

   // Forward normalize
   logic                n1_v, n1_zero;
   logic [2:0][OQW-1:0] n1_f;
   lavm_p1_type         n1_pay;

   lavm_norm #(.PW($bits(lavm_p1_type))) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t0_v_ff),
      .in_v      (fr0_ff),
      .in_pay    (p0_ff),
      .out_valid (n1_v),
      .out_q     (n1_f),
      .out_zero  (n1_zero),
      .out_pay   (n1_pay)
   );

   // T1: up x forward partial products
   logic                t1_v_ff, dg1_ff;
   logic [5:0][49:0]    pr1_ff;
   logic [2:0][31:0]    eye1_ff;
   logic [2:0][OQW-1:0] f1_ff;
   logic signed [49:0]  ux, uy, uz, fx, fy, fz;

   assign ux = 50'(signed'(n1_pay.up[0]));
   assign uy = 50'(signed'(n1_pay.up[1]));
   assign uz = 50'(signed'(n1_pay.up[2]));
   assign fx = 50'(signed'(n1_f[0]));
   assign fy = 50'(signed'(n1_f[1]));
   assign fz = 50'(signed'(n1_f[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
      end else if (en) begin
         t1_v_ff <= n1_v;
      end
      if (en) begin
         pr1_ff[0] <= uy * fz;
         pr1_ff[1] <= uz * fy;
         pr1_ff[2] <= uz * fx;
         pr1_ff[3] <= ux * fz;
         pr1_ff[4] <= ux * fy;
         pr1_ff[5] <= uy * fx;
         eye1_ff   <= n1_pay.eye;
         f1_ff     <= n1_f;
         dg1_ff    <= n1_zero;
      end
   end

   // T2: raw side vector
   logic               t2_v_ff;
   logic [2:0][VW-1:0] sr2_ff;
   lavm_p2_type        p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_v_ff <= 1'b0;
      end else if (en) begin
         t2_v_ff <= t1_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sr2_ff[i] <= VW'(signed'(pr1_ff[2*i])) - VW'(signed'(pr1_ff[2*i+1]));
         end
         p2_ff.eye   <= eye1_ff;
         p2_ff.f     <= f1_ff;
         p2_ff.degen <= dg1_ff;
      end
   end

   // Side normalize
   logic                n2_v, n2_zero;
   logic [2:0][OQW-1:0] n2_s;
   lavm_p2_type         n2_pay;

   lavm_norm #(.PW($bits(lavm_p2_type))) u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t2_v_ff),
      .in_v      (sr2_ff),
      .in_pay    (p2_ff),
      .out_valid (n2_v),
      .out_q     (n2_s),
      .out_zero  (n2_zero),
      .out_pay   (n2_pay)
   );

   // T3: forward x side products and side/forward dot partials
   logic                t3_v_ff, dg3_ff;
   logic [5:0][35:0]    fs3_ff;
   logic [2:0][49:0]    se3_ff, fe3_ff;
   logic [2:0][OQW-1:0] s3_ff, f3_ff;
   logic [2:0][31:0]    eye3_ff;
   logic signed [35:0]  a_f [3];
   logic signed [35:0]  a_s [3];
   logic signed [49:0]  w_f [3];
   logic signed [49:0]  w_s [3];
   logic signed [49:0]  w_e [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_f[i] = 36'(signed'(n2_pay.f[i]));
         a_s[i] = 36'(signed'(n2_s[i]));
         w_f[i] = 50'(signed'(n2_pay.f[i]));
         w_s[i] = 50'(signed'(n2_s[i]));
         w_e[i] = 50'(signed'(n2_pay.eye[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_v_ff <= 1'b0;
      end else if (en) begin
         t3_v_ff <= n2_v;
      end
      if (en) begin
         fs3_ff[0] <= a_f[1] * a_s[2];
         fs3_ff[1] <= a_f[2] * a_s[1];
         fs3_ff[2] <= a_f[2] * a_s[0];
         fs3_ff[3] <= a_f[0] * a_s[2];
         fs3_ff[4] <= a_f[0] * a_s[1];
         fs3_ff[5] <= a_f[1] * a_s[0];
         for (int i = 0; i < 3; i++) begin
            se3_ff[i] <= w_s[i] * w_e[i];
            fe3_ff[i] <= w_f[i] * w_e[i];
         end
         s3_ff   <= n2_s;
         f3_ff   <= n2_pay.f;
         eye3_ff <= n2_pay.eye;
         dg3_ff  <= n2_pay.degen | n2_zero;
      end
   end

   // T4: camera up, side and forward dot sums
   logic                t4_v_ff, dg4_ff;
   logic [2:0][UW-1:0]  u4_in, u4_ff;
   logic [51:0]         sd4_ff, fd4_ff;
   logic [2:0][OQW-1:0] s4_ff, f4_ff;
   logic [2:0][31:0]    eye4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u4_in[i] = UW'(rnd16(56'(signed'(fs3_ff[2*i])) - 56'(signed'(fs3_ff[2*i+1]))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_v_ff <= 1'b0;
      end else if (en) begin
         t4_v_ff <= t3_v_ff;
      end
      if (en) begin
         u4_ff   <= u4_in;
         sd4_ff  <= 52'(signed'(se3_ff[0])) + 52'(signed'(se3_ff[1]))
                  + 52'(signed'(se3_ff[2]));
         fd4_ff  <= 52'(signed'(fe3_ff[0])) + 52'(signed'(fe3_ff[1]))
                  + 52'(signed'(fe3_ff[2]));
         s4_ff   <= s3_ff;
         f4_ff   <= f3_ff;
         eye4_ff <= eye3_ff;
         dg4_ff  <= dg3_ff;
      end
   end

   // T5: camera up dot partials, finish side and forward translations
   logic                t5_v_ff, dg5_ff;
   logic [2:0][51:0]    ue5_ff;
   logic [31:0]         d0_5_ff, d2_5_ff;
   logic [2:0][OQW-1:0] s5_ff, f5_ff;
   logic [2:0][UW-1:0]  u5_ff;
   logic signed [51:0]  w_u [3];
   logic signed [51:0]  w_e4 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w_u[i]  = 52'(signed'(u4_ff[i]));
         w_e4[i] = 52'(signed'(eye4_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t5_v_ff <= 1'b0;
      end else if (en) begin
         t5_v_ff <= t4_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ue5_ff[i] <= w_u[i] * w_e4[i];
         end
         d0_5_ff <= satneg(56'(signed'(sd4_ff)));
         d2_5_ff <= satneg(56'(signed'(fd4_ff)));
         s5_ff   <= s4_ff;
         f5_ff   <= f4_ff;
         u5_ff   <= u4_ff;
         dg5_ff  <= dg4_ff;
      end
   end

   // T6: camera up dot sum
   logic                t6_v_ff, dg6_ff;
   logic [53:0]         ud6_ff;
   logic [31:0]         d0_6_ff, d2_6_ff;
   logic [2:0][OQW-1:0] s6_ff, f6_ff;
   logic [2:0][UW-1:0]  u6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t6_v_ff <= 1'b0;
      end else if (en) begin
         t6_v_ff <= t5_v_ff;
      end
      if (en) begin
         ud6_ff  <= 54'(signed'(ue5_ff[0])) + 54'(signed'(ue5_ff[1]))
                  + 54'(signed'(ue5_ff[2]));
         d0_6_ff <= d0_5_ff;
         d2_6_ff <= d2_5_ff;
         s6_ff   <= s5_ff;
         f6_ff   <= f5_ff;
         u6_ff   <= u5_ff;
         dg6_ff  <= dg5_ff;
      end
   end

   // T7: finished matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         t7_v_ff <= 1'b0;
      end else if (en) begin
         t7_v_ff <= t6_v_ff;
      end
      if (en) begin
         item_ff.s     <= s6_ff;
         item_ff.u     <= u6_ff;
         item_ff.f     <= f6_ff;
         item_ff.d     <= {d2_6_ff, satneg(56'(signed'(ud6_ff))), d0_6_ff};
         item_ff.degen <= dg6_ff;
      end
   end

   lavm_rowout u_rowout (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (t7_v_ff),
      .in_item        (item_ff),
      .in_take        (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_index  (rsp_row_index),
      .rsp_col0       (rsp_col0),
      .rsp_col1       (rsp_col1),
      .rsp_col2       (rsp_col2),
      .rsp_col3       (rsp_col3),
      .rsp_last_row   (rsp_last_row),
      .rsp_degenerate (rsp_degenerate)
   );

   // Rows of one matrix go out in order with one degenerate flag
   `LAVM_ASSERT_NEXT(a_row_step, rsp_valid && !rsp_stall && !rsp_last_row, rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1 && rsp_degenerate == $past(rsp_degenerate), "row sequence broken")
   // A new matrix always starts at row 0
   `LAVM_ASSERT_NEXT(a_row_restart, rsp_valid && !rsp_stall && rsp_last_row, !rsp_valid || rsp_row_index == ROW_FIRST, "matrix did not restart at row 0")
   // Input is held back only while a finished matrix waits at the tail
   `LAVM_ASSERT_NOW(a_stall_cause, req_stall, t7_v_ff && rsp_valid, "stall without a waiting matrix")

endmodule
